/* design/asc_pkg.sv */
package asc_pkg;

   localparam int DATA_WIDTH       = 32;
   localparam int CAPACITY_DEFAULT = 64;

   // one input word
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         last_in;
   } req_type;

   // one result word
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] sorted_value;
      logic                         last_out;
      logic                         overflowed;
   } rsp_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctl_type;

endpackage

/* design/ascending_integer_sorter.sv */
// Batch sorter for signed 32-bit integers built as a row of CAPACITY insertion
// cells. While a batch loads, one word is taken per cycle: every cell compares
// the new value against its own in parallel and the row opens a gap at the
// right place, so the row is always sorted. The word with last_in ends the
// batch; from the next cycle on, busy is high while the row shifts toward cell
// 0, one value per cycle, until all values held (1 to CAPACITY) are out; each
// result is registered from cell 0 onto rsp_word with rsp_strobe as it shifts
// out. Results come back to back and cannot be stalled: the receiver must
// take one word every cycle that rsp_strobe is high. Values that arrive once
// the row is full are dropped, and every result of that batch carries
// overflowed. Words are taken during load only: no new word is accepted
// until the drain, driven by the single shift port of the cell row, is over.
module ascending_integer_sorter #(
   parameter int CAPACITY = asc_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  asc_pkg::req_type req_word,
   output logic             rsp_strobe,
   output asc_pkg::rsp_type rsp_word
);

   typedef enum logic {
      STATE_LOAD,
      STATE_DRAIN
   } state_type;

   state_type             state_ff;
   state_type             state_in;
   logic                  dropped_ff;
   logic                  dropped_in;
   logic                  rsp_strobe_ff;
   logic                  rsp_strobe_in;
   asc_pkg::rsp_type      rsp_ff;
   asc_pkg::rsp_type      rsp_in;
   asc_pkg::cell_ctl_type ctl;
   logic                  accept;
   logic                  full;

   // per-cell views of the row
   logic [CAPACITY-1:0]                        cell_gt;
   logic [CAPACITY-1:0]                        cell_valid;
   logic signed [asc_pkg::DATA_WIDTH-1:0]      cell_value [CAPACITY];

   assign accept = start && (state_ff == STATE_LOAD);
   // row full: the rightmost cell is occupied
   assign full   = cell_valid[CAPACITY-1];

   assign ctl.insert = accept && !full;
   assign ctl.shift  = (state_ff == STATE_DRAIN);

   // the cell row
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                                 left_gt;
      logic                                 left_valid;
      logic signed [asc_pkg::DATA_WIDTH-1:0] left_value;
      logic                                 right_valid;
      logic signed [asc_pkg::DATA_WIDTH-1:0] right_value;

      if (i == 0) begin : g_head
         // nothing to the left: the new value itself enters here
         assign left_gt    = 1'b0;
         assign left_valid = 1'b1;
         assign left_value = req_word.value;
      end else begin : g_body
         assign left_gt    = cell_gt[i-1];
         assign left_valid = cell_valid[i-1];
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         // an empty slot shifts in from past the end
         assign right_valid = 1'b0;
         assign right_value = '0;
      end else begin : g_inner
         assign right_valid = cell_valid[i+1];
         assign right_value = cell_value[i+1];
      end

      asc_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .new_value   (req_word.value),
         .left_gt     (left_gt),
         .left_valid  (left_valid),
         .left_value  (left_value),
         .right_valid (right_valid),
         .right_value (right_value),
         .gt          (cell_gt[i]),
         .valid       (cell_valid[i]),
         .value       (cell_value[i])
      );
   end

   // load and drain control
   always_comb begin
      state_in      = state_ff;
      dropped_in    = dropped_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      case (state_ff)
         STATE_LOAD: begin
            if (accept) begin
               // a word that finds the row full is dropped, last word included
               dropped_in = dropped_ff | full;
               if (req_word.last_in) begin
                  state_in = STATE_DRAIN;
               end
            end
         end
         STATE_DRAIN: begin
            // cell 0 always holds the smallest value left
            rsp_strobe_in       = 1'b1;
            rsp_in.sorted_value = cell_value[0];
            rsp_in.last_out     = !cell_valid[1];
            rsp_in.overflowed   = dropped_ff;
            if (!cell_valid[1]) begin
               state_in   = STATE_LOAD;
               dropped_in = 1'b0;
            end
         end
         default: begin
            state_in = STATE_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_LOAD;
         dropped_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         dropped_ff    <= dropped_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // result payload needs no reset
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff == STATE_DRAIN);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

`ifndef NO_ASSERTIONS
   // occupied cells always form an unbroken run from cell 0
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      ((cell_valid >> 1) & ~cell_valid) == '0)
      else $error("cell row has a hole");

   // results of one batch leave in ascending order, without gaps
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_word.last_out |=>
         rsp_strobe && (rsp_word.sorted_value >= $past(rsp_word.sorted_value)))
      else $error("result stream out of order or broken");

   // once the final word of a batch is out, the block is ready again
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.last_out |-> !busy && (cell_valid == '0))
      else $error("cells still occupied after final word");
`endif

endmodule

/* design/asc_cell.sv */
module asc_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  asc_pkg::cell_ctl_type                ctl,
   input  logic signed [asc_pkg::DATA_WIDTH-1:0] new_value,
   input  logic                                 left_gt,
   input  logic                                 left_valid,
   input  logic signed [asc_pkg::DATA_WIDTH-1:0] left_value,
   input  logic                                 right_valid,
   input  logic signed [asc_pkg::DATA_WIDTH-1:0] right_value,
   output logic                                 gt,
   output logic                                 valid,
   output logic signed [asc_pkg::DATA_WIDTH-1:0] value
);

   logic                                 valid_ff;
   logic                                 valid_in;
   logic signed [asc_pkg::DATA_WIDTH-1:0] value_ff;
   logic signed [asc_pkg::DATA_WIDTH-1:0] value_in;

   // empty cells count as greater so the new value lands at the end of the run
   assign gt = !valid_ff || (value_ff > new_value);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctl.shift) begin
         valid_in = right_valid;
         value_in = right_value;
      end else if (ctl.insert && gt) begin
         valid_in = valid_ff | left_valid;
         value_in = left_gt ? left_value : new_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;

endmodule
